FILE: rtl/linear_partition_min_max_load_unit_assert.svh
// Assertion macros used by the checker module of the load unit.
// Expects clk and rst in the scope of each use.
`ifndef LINEAR_PARTITION_MIN_MAX_LOAD_UNIT_ASSERT_SVH
`define LINEAR_PARTITION_MIN_MAX_LOAD_UNIT_ASSERT_SVH

// same-cycle implication
`define LPMM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpmm: same-cycle check failed");

// next-cycle implication
`define LPMM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpmm: next-cycle check failed");

`endif

FILE: rtl/lpmm_pkg.sv
// Shared widths, register indexes and sequencer states of the load unit.
// No dependencies.
package lpmm_pkg;

  localparam int LEN_W          = 17;
  localparam int PC_W           = 17;
  localparam int UT_W           = 20;
  localparam int TOT_W          = 27;
  localparam int OUT_W          = TOT_W + UT_W;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = UT_W;
  localparam int MAX_BOARDS_DEF = 1024;

  localparam logic [CFG_IDX_W-1:0] CFG_PAINTER_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_TIME     = 2'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOP,
    S_SCAN,
    S_MUL,
    S_OUT
  } state_t;

endpackage

FILE: rtl/lpmm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lpmm_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/linear_partition_min_max_load_unit.sv
// Painter's partition unit: loads board lengths, then binary-searches the least max group load.
// Depends on lpmm_pkg and lpmm_ram.
//
// A board that is not marked last is taken while idle and busy stays low. A board marked last
// starts the search: each probe scans the N stored boards through the single RAM read port,
// one board per cycle (a failing probe stops early); the search runs at most
// floor(log2(total - least + 1)) + 1 probes, followed by the closing range check (S_LOOP),
// the product with unit_time (S_MUL) and the output (S_OUT). done is high for exactly one cycle
// with min_time; the receiver cannot stall it, and the next transaction is taken the cycle
// after done. Configuration writes are always ready and must only come while busy is low.
module linear_partition_min_max_load_unit #(
  parameter int MAX_BOARDS = lpmm_pkg::MAX_BOARDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [lpmm_pkg::LEN_W-1:0]     board_length,
  input  logic                           last_board,
  output logic                           done,
  output logic [lpmm_pkg::OUT_W-1:0]     min_time,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lpmm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lpmm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lpmm_pkg::*;

  localparam int CNT_W  = $clog2(MAX_BOARDS + 1);
  localparam int ADDR_W = (MAX_BOARDS > 1) ? $clog2(MAX_BOARDS) : 1;

  state_t state, state_next;

  logic [PC_W-1:0]         painter_count;
  logic [UT_W-1:0]         unit_time;
  logic [CNT_W-1:0]        board_count;
  logic [TOT_W-1:0]        total_length;
  logic [LEN_W-1:0]        least_length;
  logic [CNT_W-1:0]        scan_count;
  logic signed [TOT_W:0]   search_low;
  logic signed [TOT_W:0]   search_high;
  logic [TOT_W-1:0]        best_load;
  logic [TOT_W-1:0]        mid;
  logic [TOT_W:0]          run;
  logic [PC_W-1:0]         left;
  logic [CNT_W-1:0]        rd_cnt;
  logic [CNT_W-1:0]        proc_cnt;
  logic                    rd_pend;
  logic [OUT_W-1:0]        product;

  logic                    accept;
  logic                    store_ok;
  logic [TOT_W-1:0]        total_new;
  logic [LEN_W-1:0]        least_new;
  logic [CNT_W-1:0]        count_new;
  logic [PC_W-1:0]         groups;
  logic                    range_open;
  logic signed [TOT_W:0]   span;
  logic [TOT_W-1:0]        mid_calc;
  logic                    issue;
  logic [LEN_W-1:0]        rdata;
  logic [TOT_W:0]          b_ext;
  logic [TOT_W:0]          run_sum;
  logic                    probe_fail;
  logic                    probe_last;

  assign cfg_ready = 1'b1;
  assign min_time  = product;

  assign accept    = start && (state == S_IDLE);
  assign store_ok  = board_count < CNT_W'(MAX_BOARDS);
  assign total_new = store_ok ? total_length + TOT_W'(board_length) : total_length;
  assign least_new = (store_ok && (board_length <= least_length)) ? board_length : least_length;
  assign count_new = store_ok ? board_count + 1'b1 : board_count;
  assign groups    = (painter_count == '0) ? PC_W'(1) : painter_count;

  assign range_open = search_low <= search_high;
  assign span       = search_high - search_low;
  assign mid_calc   = TOT_W'(search_low + (span >>> 1));

  assign issue      = (state == S_SCAN) && (rd_cnt < scan_count);
  assign b_ext      = (TOT_W + 1)'(rdata);
  assign run_sum    = run + b_ext;
  assign probe_fail = (b_ext > {1'b0, mid}) ||
                      ((run_sum > {1'b0, mid}) && (left == PC_W'(1)));
  assign probe_last = proc_cnt == scan_count - 1'b1;

  lpmm_ram #(
    .WIDTH (LEN_W),
    .DEPTH (MAX_BOARDS)
  ) u_store (
    .clk   (clk),
    .we    (accept && store_ok),
    .waddr (board_count[ADDR_W-1:0]),
    .wdata (board_length),
    .re    (issue),
    .raddr (rd_cnt[ADDR_W-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start && last_board) begin
          state_next = S_LOOP;
        end
      end
      S_LOOP: begin
        state_next = range_open ? S_SCAN : S_MUL;
      end
      S_SCAN: begin
        if (rd_pend && (probe_fail || probe_last)) begin
          state_next = S_LOOP;
        end
      end
      S_MUL: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      painter_count <= PC_W'(1);
      unit_time     <= UT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PAINTER_COUNT: painter_count <= cfg_data[PC_W-1:0];
        CFG_UNIT_TIME:     unit_time     <= cfg_data[UT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      board_count  <= '0;
      total_length <= '0;
      least_length <= '1;
      search_low   <= '0;
      search_high  <= '0;
      best_load    <= '0;
      rd_pend      <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (last_board) begin
              scan_count   <= count_new;
              search_low   <= (TOT_W + 1)'(least_new);
              search_high  <= (TOT_W + 1)'(total_new);
              best_load    <= '0;
              board_count  <= '0;
              total_length <= '0;
              least_length <= '1;
            end else begin
              board_count  <= count_new;
              total_length <= total_new;
              least_length <= least_new;
            end
          end
        end
        S_LOOP: begin
          mid      <= mid_calc;
          rd_cnt   <= '0;
          proc_cnt <= '0;
          rd_pend  <= 1'b0;
          run      <= '0;
          left     <= groups;
        end
        S_SCAN: begin
          rd_cnt  <= rd_cnt + CNT_W'(issue);
          rd_pend <= issue;
          if (rd_pend) begin
            if (probe_fail) begin
              search_low <= (TOT_W + 1)'(mid) + 1'b1;
            end else if (probe_last) begin
              best_load   <= mid;
              search_high <= (TOT_W + 1)'(mid) - 1'b1;
            end else begin
              proc_cnt <= proc_cnt + 1'b1;
              if (run_sum > {1'b0, mid}) begin
                left <= left - 1'b1;
                run  <= b_ext;
              end else begin
                run <= run_sum;
              end
            end
          end
        end
        S_MUL: begin
          product <= OUT_W'(best_load) * OUT_W'(unit_time);
        end
        S_OUT: ;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/lpmm_checker.sv
// Port-level checker for the load unit, bound to the top level.
// Depends on linear_partition_min_max_load_unit_assert.svh.
`include "linear_partition_min_max_load_unit_assert.svh"

module lpmm_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic last_board,
  input logic done
);

  `LPMM_ASSERT_SAME(a_done_busy, done, busy)
  `LPMM_ASSERT_NEXT(a_done_idle, done, !busy && !done)
  `LPMM_ASSERT_NEXT(a_load_quick, start && !busy && !last_board, !busy)
  `LPMM_ASSERT_NEXT(a_last_search, start && !busy && last_board, busy)

endmodule

bind linear_partition_min_max_load_unit lpmm_checker u_lpmm_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .last_board (last_board),
  .done       (done)
);
